### rtl/core/sm4_pkg.sv
// Shared types, constants and byte-substitution table for the SM4 cipher core.
// No dependencies; imported by every module in rtl/core.
package sm4_pkg;

    localparam int ROUNDS    = 32;
    localparam int RK_AW     = $clog2(ROUNDS);
    localparam int KEY_REGS  = 4;
    localparam int KEY_AW    = $clog2(KEY_REGS);
    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef logic [31:0] word_t;

    // write request into the round-key store
    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        word_t            data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic word_t sbox_word(word_t v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // CK constant: byte j of word i is 7*(4i+j) mod 256
    function automatic word_t ck_word(logic [RK_AW-1:0] i);
        word_t      c;
        logic [9:0] prod;
        c = '0;
        for (int j = 0; j < 4; j++)
        begin
            prod = {1'b0, i, 2'(j), 2'b00} >> 2;
            prod = 10'(prod * 10'd7);
            c[31-8*j -: 8] = prod[7:0];
        end
        return c;
    endfunction

endpackage

### rtl/core/sm4_round.sv
// Shared SM4 round unit: S-box substitution and linear mix, data or key form.
// Depends on sm4_pkg.
module sm4_round (
    input  sm4_pkg::word_t w0,
    input  sm4_pkg::word_t w1,
    input  sm4_pkg::word_t w2,
    input  sm4_pkg::word_t w3,
    input  sm4_pkg::word_t rk,
    input  logic           key_mode,
    output sm4_pkg::word_t nx
);
    import sm4_pkg::*;

    word_t sub;
    word_t mix;

    always_comb
    begin
        sub = sbox_word(w1 ^ w2 ^ w3 ^ rk);
        if (key_mode)
        begin
            mix = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
        end
        else
        begin
            mix = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
                      ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
        end
        nx = w0 ^ mix;
    end

endmodule

### rtl/core/sm4_rk_store.sv
// Round-key store: one word per round, filled during key expansion.
// Depends on sm4_pkg.
module sm4_rk_store (
    input  logic                      clk,
    input  sm4_pkg::rk_wr_t           wr,
    input  logic [sm4_pkg::RK_AW-1:0] rd_addr,
    output sm4_pkg::word_t            rd_data
);
    import sm4_pkg::*;

    word_t keys_reg [ROUNDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            keys_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = keys_reg[rd_addr];

endmodule

### rtl/core/sm4_block_cipher_unit.sv
// SM4 block cipher top level: key registers, sequencer and round state.
// Depends on sm4_pkg, sm4_round and sm4_rk_store.
//
//   channel   handshake        payload
//   -------   --------------   ---------------------------------------------
//   request   start / busy     block_word0..3, decrypt
//   result    done (1 cycle)   out_word0..3
//   config    cfg_write        cfg_index, cfg_data (key_word0..3 at 0..3)
//
// A request runs 32 rounds, one per cycle, through the single round unit; done
// follows the last round, and no new request is taken until then.
// After reset and after any key write, key expansion uses the same round unit
// for one load step and 32 rounds; busy stays high throughout.
// done is high for one cycle, with no stall; out_word0..3 hold until the next result.
module sm4_block_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   block_word0,
    input  logic [31:0]                   block_word1,
    input  logic [31:0]                   block_word2,
    input  logic [31:0]                   block_word3,
    input  logic                          decrypt,
    output logic                          done,
    output logic [31:0]                   out_word0,
    output logic [31:0]                   out_word1,
    output logic [31:0]                   out_word2,
    output logic [31:0]                   out_word3,
    input  logic                          cfg_write,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import sm4_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KLOAD = 2'd1;
    localparam logic [1:0] ST_KEXP  = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RK_AW-1:0] cnt_reg, cnt_next;
    logic             dirty_reg, dirty_next;
    logic             dec_reg, dec_next;
    logic             done_reg, done_next;
    word_t            key_reg [KEY_REGS];
    word_t            x_reg [4];
    word_t            x_next [4];
    word_t            out_reg [4];
    word_t            out_next [4];

    logic             accept;
    logic             last;
    logic             key_hit;
    word_t            rk_sel;
    word_t            rk_rd;
    word_t            nx;
    logic [RK_AW-1:0] rd_addr;
    rk_wr_t           rk_wr;

    assign accept  = start && !busy;
    assign last    = (cnt_reg == RK_AW'(ROUNDS - 1));
    assign key_hit = cfg_write && (cfg_index < CFG_IDX_W'(KEY_REGS));
    assign rd_addr = dec_reg ? ~cnt_reg : cnt_reg;
    assign rk_sel  = (state_reg == ST_KEXP) ? ck_word(cnt_reg) : rk_rd;

    sm4_round u_round (
        .w0       (x_reg[0]),
        .w1       (x_reg[1]),
        .w2       (x_reg[2]),
        .w3       (x_reg[3]),
        .rk       (rk_sel),
        .key_mode (state_reg == ST_KEXP),
        .nx       (nx)
    );

    sm4_rk_store u_rk_store (
        .clk     (clk),
        .wr      (rk_wr),
        .rd_addr (rd_addr),
        .rd_data (rk_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dirty_next = dirty_reg || key_hit;
        dec_next   = dec_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        out_next   = out_reg;
        rk_wr.en   = 1'b0;
        rk_wr.addr = cnt_reg;
        rk_wr.data = nx;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next[0]  = block_word0;
                    x_next[1]  = block_word1;
                    x_next[2]  = block_word2;
                    x_next[3]  = block_word3;
                    dec_next   = decrypt;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
                else if (dirty_reg)
                begin
                    dirty_next = key_hit;
                    state_next = ST_KLOAD;
                end
            end
            ST_KLOAD:
            begin
                x_next[0]  = key_reg[0] ^ FK0;
                x_next[1]  = key_reg[1] ^ FK1;
                x_next[2]  = key_reg[2] ^ FK2;
                x_next[3]  = key_reg[3] ^ FK3;
                cnt_next   = '0;
                state_next = ST_KEXP;
            end
            ST_KEXP:
            begin
                rk_wr.en  = 1'b1;
                x_next[0] = x_reg[1];
                x_next[1] = x_reg[2];
                x_next[2] = x_reg[3];
                x_next[3] = nx;
                cnt_next  = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                x_next[0] = x_reg[1];
                x_next[1] = x_reg[2];
                x_next[2] = x_reg[3];
                x_next[3] = nx;
                cnt_next  = cnt_reg + 1'b1;
                if (last)
                begin
                    // drop the words out in reverse order
                    out_next[0] = nx;
                    out_next[1] = x_reg[3];
                    out_next[2] = x_reg[2];
                    out_next[3] = x_reg[1];
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dirty_reg <= 1'b1;
            dec_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dirty_reg <= dirty_next;
            dec_reg   <= dec_next;
            done_reg  <= done_next;
            if (key_hit)
            begin
                key_reg[cfg_index[KEY_AW-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    // hold off requests while a block is running or keys are stale or being expanded
    assign busy      = (state_reg != ST_IDLE) || dirty_reg;
    assign done      = done_reg;
    assign out_word0 = out_reg[0];
    assign out_word1 = out_reg[1];
    assign out_word2 = out_reg[2];
    assign out_word3 = out_reg[3];

endmodule
